### rtl/cwg_pkg.sv
// ----------------------------------------------------------------------------
// cwg_pkg
// Shared types and codes for the convolution weight-gradient block.
// ----------------------------------------------------------------------------
`default_nettype none

package cwg_pkg;

  // Item command codes
  localparam logic [1:0] CMD_LOAD_ACT  = 2'd0;
  localparam logic [1:0] CMD_LOAD_GRAD = 2'd1;
  localparam logic [1:0] CMD_COMPUTE   = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] REG_IN_ROWS      = 3'd0;
  localparam logic [2:0] REG_IN_COLS      = 3'd1;
  localparam logic [2:0] REG_KERNEL_ROWS  = 3'd2;
  localparam logic [2:0] REG_KERNEL_COLS  = 3'd3;
  localparam logic [2:0] REG_IN_CHANNELS  = 3'd4;
  localparam logic [2:0] REG_OUT_CHANNELS = 3'd5;
  localparam logic [2:0] REG_PADDING      = 3'd6;

  // Result status codes
  localparam logic STAT_OK  = 1'b0;
  localparam logic STAT_ERR = 1'b1;

  // Geometry as seen by the control logic
  typedef struct packed {
    logic        ok;
    logic        settled;
    logic [6:0]  in_rows;
    logic [6:0]  in_cols;
    logic [4:0]  kernel_rows;
    logic [4:0]  kernel_cols;
    logic [4:0]  in_channels;
    logic [4:0]  out_channels;
    logic [3:0]  padding;
    logic [7:0]  out_rows;
    logic [7:0]  out_cols;
    logic [13:0] act_map;
    logic [15:0] grad_map;
  } geo_t;

endpackage

`default_nettype wire

### rtl/conv_weight_gradient.sv
// ----------------------------------------------------------------------------
// conv_weight_gradient
// Weight-gradient kernel of a padded multi-channel 2-D convolution layer.
// ----------------------------------------------------------------------------
//  channel  dir  ports                                  beat
//  in       in   command out_chan in_chan row col value  one load or compute
//  out      out  grad_sum status                        one result
//  cfg      in   index data                             one register write
//
//  A load passes through S_ADDR1 and S_ADDR2 and yields no result unless it
//  is rejected. A compute walks every output position in S_RUN with one store
//  read pair per output position, then drains the read/multiply/accumulate
//  pipe in S_DRAIN. Rejected items go from S_IDLE straight to S_OUT with an
//  error result. A config write holds off input beats while geometry settles.
//  Synchronous active-low reset; stores are not cleared. A waiting result
//  does not block the next input beat.
// ----------------------------------------------------------------------------
`default_nettype none

module conv_weight_gradient #(
  parameter int ACT_DEPTH    = 4096,
  parameter int GRAD_DEPTH   = 4096,
  parameter int MAX_DIM      = 64,
  parameter int MAX_CHANNELS = 16,
  parameter int ACC_WIDTH    = 48
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_command,
  input  wire logic [3:0]  in_out_chan,
  input  wire logic [3:0]  in_in_chan,
  input  wire logic [5:0]  in_row,
  input  wire logic [5:0]  in_col,
  input  wire logic [15:0] in_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [47:0]      out_grad_sum,
  output logic             out_status,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [6:0]  cfg_data
);

  localparam int AW = $clog2(ACT_DEPTH);
  localparam int GW = $clog2(GRAD_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE, S_ADDR1, S_ADDR2, S_RUN, S_DRAIN, S_OUT
  } state_t;

  cwg_pkg::geo_t geo;

  state_t             state_r;
  logic [1:0]         cmd_r;
  logic [3:0]         oc_r, ic_r;
  logic [5:0]         row_r, col_r;
  logic [15:0]        val_r;
  logic [12:0]        t1_r;
  logic [17:0]        p1_r;
  logic [19:0]        p2_r;
  logic signed [9:0]  xi0_r, yi0_r, xi_r, yi_r;
  logic signed [21:0] arow_r;
  logic [19:0]        gi_r;
  logic [7:0]         xo_r, yo_r;
  logic [1:0]         drain_r;
  logic               tag_r;
  logic [47:0]        res_sum_r;
  logic               res_stat_r;
  logic               out_valid_r;
  logic [47:0]        out_sum_r;
  logic               out_stat_r;

  logic               accept, bad;
  logic [21:0]        ld_idx;
  logic               act_we, grad_we;
  logic signed [21:0] ai;
  logic               pos_ok, issue;
  logic [15:0]        act_rd, grad_rd;
  logic [47:0]        mac_sum;
  logic               load_out;

  cwg_geom #(
    .ACT_DEPTH(ACT_DEPTH), .GRAD_DEPTH(GRAD_DEPTH),
    .MAX_DIM(MAX_DIM), .MAX_CHANNELS(MAX_CHANNELS)
  ) u_geom (
    .clk(clk), .rst_n(rst_n), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .geo(geo)
  );

  assign in_ready = (state_r == S_IDLE) && geo.settled;
  assign accept   = in_valid && in_ready;

  // reject check on the incoming beat
  always_comb begin
    case (in_command)
      cwg_pkg::CMD_LOAD_ACT:
        bad = ({3'b0, in_in_chan} >= {2'b0, geo.in_channels}) ||
              ({1'b0, in_row} >= geo.in_rows) || ({1'b0, in_col} >= geo.in_cols);
      cwg_pkg::CMD_LOAD_GRAD:
        bad = ({3'b0, in_out_chan} >= {2'b0, geo.out_channels}) ||
              ({2'b0, in_row} >= geo.out_rows) || ({2'b0, in_col} >= geo.out_cols);
      cwg_pkg::CMD_COMPUTE:
        bad = ({1'b0, in_out_chan} >= geo.out_channels) ||
              ({1'b0, in_in_chan} >= geo.in_channels) ||
              (in_row >= {1'b0, geo.kernel_rows}) || (in_col >= {1'b0, geo.kernel_cols});
      default: bad = 1'b1;
    endcase
    bad = bad || !geo.ok;
  end

  // load address, second multiply
  assign ld_idx = (cmd_r == cwg_pkg::CMD_LOAD_ACT) ?
                  22'(t1_r * geo.in_cols) + 22'(col_r) :
                  22'(t1_r * geo.out_cols) + 22'(col_r);
  assign act_we  = (state_r == S_ADDR2) && (cmd_r == cwg_pkg::CMD_LOAD_ACT);
  assign grad_we = (state_r == S_ADDR2) && (cmd_r == cwg_pkg::CMD_LOAD_GRAD);

  // compute walk: activation address and padding test
  assign ai     = arow_r + 22'(yi_r);
  assign pos_ok = !xi_r[9] && (xi_r[8:0] < {2'b0, geo.in_rows}) &&
                  !yi_r[9] && (yi_r[8:0] < {2'b0, geo.in_cols});
  assign issue  = (state_r == S_RUN) && pos_ok;

  cwg_ram #(.DEPTH(ACT_DEPTH), .WIDTH(16)) u_act (
    .clk(clk), .we(act_we), .waddr(ld_idx[AW-1:0]), .wdata(val_r),
    .raddr(ai[AW-1:0]), .rdata(act_rd)
  );

  cwg_ram #(.DEPTH(GRAD_DEPTH), .WIDTH(16)) u_grad (
    .clk(clk), .we(grad_we), .waddr(ld_idx[GW-1:0]), .wdata(val_r),
    .raddr(gi_r[GW-1:0]), .rdata(grad_rd)
  );

  cwg_mac #(.ACC_WIDTH(ACC_WIDTH)) u_mac (
    .clk(clk), .rst_n(rst_n), .clear(state_r == S_ADDR2),
    .vld(tag_r), .a($signed(grad_rd)), .b($signed(act_rd)), .sum(mac_sum)
  );

  assign load_out = (state_r == S_OUT) && (!out_valid_r || out_ready);

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tag_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      tag_r <= issue;
      if (load_out) begin
        out_valid_r <= 1'b1;
        out_sum_r   <= res_sum_r;
        out_stat_r  <= res_stat_r;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            cmd_r <= in_command;
            oc_r  <= in_out_chan;
            ic_r  <= in_in_chan;
            row_r <= in_row;
            col_r <= in_col;
            val_r <= in_value;
            if (bad) begin
              res_sum_r  <= '0;
              res_stat_r <= cwg_pkg::STAT_ERR;
              state_r    <= S_OUT;
            end else begin
              state_r <= S_ADDR1;
            end
          end
        end
        S_ADDR1: begin
          t1_r  <= (cmd_r == cwg_pkg::CMD_LOAD_ACT) ?
                   13'(ic_r * geo.in_rows) + 13'(row_r) :
                   13'(oc_r * geo.out_rows) + 13'(row_r);
          p1_r  <= 18'(ic_r * geo.act_map);
          p2_r  <= 20'(oc_r * geo.grad_map);
          xi0_r <= $signed(10'(geo.kernel_rows)) - 10'sd1 -
                   $signed(10'(geo.padding)) - $signed(10'(row_r));
          yi0_r <= $signed(10'(geo.kernel_cols)) - 10'sd1 -
                   $signed(10'(geo.padding)) - $signed(10'(col_r));
          state_r <= S_ADDR2;
        end
        S_ADDR2: begin
          if (cmd_r == cwg_pkg::CMD_COMPUTE) begin
            arow_r  <= $signed({4'b0, p1_r}) +
                       22'(xi0_r * $signed({1'b0, geo.in_cols}));
            gi_r    <= p2_r;
            xi_r    <= xi0_r;
            yi_r    <= yi0_r;
            xo_r    <= '0;
            yo_r    <= '0;
            state_r <= S_RUN;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_RUN: begin
          gi_r <= gi_r + 20'd1;
          if (yo_r == geo.out_cols - 8'd1) begin
            yo_r   <= '0;
            yi_r   <= yi0_r;
            xo_r   <= xo_r + 8'd1;
            xi_r   <= xi_r + 10'sd1;
            arow_r <= arow_r + $signed({15'b0, geo.in_cols});
            if (xo_r == geo.out_rows - 8'd1) begin
              drain_r <= 2'd2;
              state_r <= S_DRAIN;
            end
          end else begin
            yo_r <= yo_r + 8'd1;
            yi_r <= yi_r + 10'sd1;
          end
        end
        S_DRAIN: begin
          if (drain_r == 2'd0) begin
            res_sum_r  <= mac_sum;
            res_stat_r <= cwg_pkg::STAT_OK;
            state_r    <= S_OUT;
          end else begin
            drain_r <= drain_r - 2'd1;
          end
        end
        S_OUT: begin
          if (load_out) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid    = out_valid_r;
  assign out_grad_sum = out_sum_r;
  assign out_status   = out_stat_r;

  // checks
  a_tag_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    tag_r |-> (state_r == S_RUN || state_r == S_DRAIN))
    else $error("accumulate tag outside compute walk");
  a_no_accept_settling: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> geo.settled)
    else $error("beat accepted while geometry settles");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> (out_grad_sum == 48'd0))
    else $error("error result with nonzero sum");
  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(act_we && grad_we))
    else $error("both stores written at once");

endmodule

`default_nettype wire

### rtl/cwg_ram.sv
// ----------------------------------------------------------------------------
// cwg_ram
// Single write port, single read port memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cwg_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/cwg_geom.sv
// ----------------------------------------------------------------------------
// cwg_geom
// Configuration registers and a three-stage geometry check.
// ----------------------------------------------------------------------------
`default_nettype none

module cwg_geom #(
  parameter int ACT_DEPTH    = 4096,
  parameter int GRAD_DEPTH   = 4096,
  parameter int MAX_DIM      = 64,
  parameter int MAX_CHANNELS = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [2:0] cfg_index,
  input  wire logic [6:0] cfg_data,
  output cwg_pkg::geo_t   geo
);

  logic [6:0]  in_rows_r, in_cols_r;
  logic [4:0]  kr_r, kc_r, ich_r, och_r;
  logic [3:0]  pad_r;
  logic [1:0]  settle_r;

  logic [7:0]  pr, pc;
  logic        base_ok;
  logic [7:0]  orows_r, ocols_r;
  logic [13:0] act_map_r;
  logic        ok1_r, ok2_r, ok_r;
  logic [18:0] act_tot_r;
  logic [15:0] grad_map_r;
  logic [20:0] grad_tot;

  assign cfg_ready = 1'b1;

  // register file; a write restarts the settle count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_rows_r <= 7'd8;
      in_cols_r <= 7'd8;
      kr_r      <= 5'd3;
      kc_r      <= 5'd3;
      ich_r     <= 5'd1;
      och_r     <= 5'd1;
      pad_r     <= 4'd0;
      settle_r  <= 2'd3;
    end else begin
      if (cfg_valid) begin
        settle_r <= 2'd3;
        case (cfg_index)
          cwg_pkg::REG_IN_ROWS:      in_rows_r <= cfg_data;
          cwg_pkg::REG_IN_COLS:      in_cols_r <= cfg_data;
          cwg_pkg::REG_KERNEL_ROWS:  kr_r      <= cfg_data[4:0];
          cwg_pkg::REG_KERNEL_COLS:  kc_r      <= cfg_data[4:0];
          cwg_pkg::REG_IN_CHANNELS:  ich_r     <= cfg_data[4:0];
          cwg_pkg::REG_OUT_CHANNELS: och_r     <= cfg_data[4:0];
          cwg_pkg::REG_PADDING:      pad_r     <= cfg_data[3:0];
          default: ;
        endcase
      end else if (settle_r != 2'd0) begin
        settle_r <= settle_r - 2'd1;
      end
    end
  end

  // stage 1: padded size, output size, range checks, input map size
  assign pr = {1'b0, in_rows_r} + {3'b0, pad_r, 1'b0};
  assign pc = {1'b0, in_cols_r} + {3'b0, pad_r, 1'b0};
  assign base_ok = (in_rows_r != 7'd0) && (32'(in_rows_r) <= 32'(MAX_DIM)) &&
                   (in_cols_r != 7'd0) && (32'(in_cols_r) <= 32'(MAX_DIM)) &&
                   (kr_r != 5'd0) && (kc_r != 5'd0) &&
                   (ich_r != 5'd0) && (32'(ich_r) <= 32'(MAX_CHANNELS)) &&
                   (och_r != 5'd0) && (32'(och_r) <= 32'(MAX_CHANNELS)) &&
                   ({3'b0, kr_r} <= pr) && ({3'b0, kc_r} <= pc);

  always_ff @(posedge clk) begin
    orows_r   <= pr - {3'b0, kr_r} + 8'd1;
    ocols_r   <= pc - {3'b0, kc_r} + 8'd1;
    act_map_r <= 14'(in_rows_r * in_cols_r);
    ok1_r     <= base_ok;
    // stage 2: input channel total and output map size
    act_tot_r  <= 19'(ich_r * act_map_r);
    grad_map_r <= 16'(orows_r * ocols_r);
    ok2_r      <= ok1_r;
    // stage 3: output channel total and store fit
    ok_r <= ok2_r && (32'(act_tot_r) <= 32'(ACT_DEPTH)) &&
            (32'(grad_tot) <= 32'(GRAD_DEPTH));
  end

  assign grad_tot = 21'(och_r * grad_map_r);

  always_comb begin
    geo.ok           = ok_r;
    geo.settled      = (settle_r == 2'd0);
    geo.in_rows      = in_rows_r;
    geo.in_cols      = in_cols_r;
    geo.kernel_rows  = kr_r;
    geo.kernel_cols  = kc_r;
    geo.in_channels  = ich_r;
    geo.out_channels = och_r;
    geo.padding      = pad_r;
    geo.out_rows     = orows_r;
    geo.out_cols     = ocols_r;
    geo.act_map      = act_map_r;
    geo.grad_map     = grad_map_r;
  end

endmodule

`default_nettype wire

### rtl/cwg_mac.sv
// ----------------------------------------------------------------------------
// cwg_mac
// Registered multiply, 64-bit accumulate and saturation to ACC_WIDTH bits.
// ----------------------------------------------------------------------------
`default_nettype none

module cwg_mac #(
  parameter int ACC_WIDTH = 48
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               clear,
  input  wire logic               vld,
  input  wire logic signed [15:0] a,
  input  wire logic signed [15:0] b,
  output logic             [47:0] sum
);

  localparam logic signed [63:0] HI = (64'sd1 <<< (ACC_WIDTH - 1)) - 64'sd1;
  localparam logic signed [63:0] LO = -HI - 64'sd1;

  logic signed [31:0] prod_r;
  logic               pv_r;
  logic signed [63:0] acc_r;
  logic signed [63:0] sat;

  // product stage then accumulate
  always_ff @(posedge clk) begin
    prod_r <= a * b;
    if (!rst_n || clear) begin
      pv_r  <= 1'b0;
      acc_r <= '0;
    end else begin
      pv_r <= vld;
      if (pv_r) begin
        acc_r <= acc_r + 64'(prod_r);
      end
    end
  end

  always_comb begin
    if (acc_r > HI) begin
      sat = HI;
    end else if (acc_r < LO) begin
      sat = LO;
    end else begin
      sat = acc_r;
    end
  end

  assign sum = sat[47:0];

endmodule

`default_nettype wire
